@@ src/mdeg_pkg.sv @@
// Shared constants for the minimum duration event gate.
package mdeg_pkg;

    localparam int THR_W = 16;
    localparam int RUN_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int MAX_RUN_LENGTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;
    localparam logic [RUN_W-1:0] RUN_RESET = 6'd10;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_RUN_LENGTH = 1'b1;

endpackage

@@ src/min_duration_event_gate_unit.sv @@
// Top level of the minimum duration event gate with its sequencer and sample store.
//
// Each sample is compared with the threshold; active samples of a run are held in
// a store until the run reaches the minimum length, then released in order, and
// later samples of the run pass straight through. A run cut short by an inactive
// sample or by the end of the frame comes out as the same number of zeros, and an
// inactive sample itself comes out as zero. One comparator is shared by the
// threshold test, the run length test and the release loop, and the store has one
// read port with registered data. Each held sample that is released is first read
// from the store and then loaded into the output; a load waits while the output is
// stalled. The block takes no new item until the current one has put its last
// result into the output register; that register lets the next item in while its
// result waits.
module min_duration_event_gate_unit #(
    parameter int MAX_RUN_LENGTH = mdeg_pkg::MAX_RUN_LENGTH_DEF,
    parameter int SAMPLE_BITS = mdeg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdeg_pkg::ADDR_W-1:0] paddr,
    input  logic [mdeg_pkg::DATA_W-1:0] pwdata,
    output logic [mdeg_pkg::DATA_W-1:0] prdata,
    output logic                        pready,

    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [SAMPLE_BITS-1:0]      i_sample_value,
    input  logic                        i_frame_end,

    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SAMPLE_BITS-1:0]      o_gated_value,
    output logic                        o_burst_last,
    output logic                        o_frame_done
);

    localparam int CNT_W = $clog2(MAX_RUN_LENGTH + 1);
    localparam int IDX_W = $clog2(MAX_RUN_LENGTH);
    localparam int CMP_W1 = (SAMPLE_BITS > mdeg_pkg::THR_W) ? SAMPLE_BITS : mdeg_pkg::THR_W;
    localparam int CMP_W = (CMP_W1 > CNT_W) ? CMP_W1 : CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_CHECK,
        S_RD,
        S_OUT,
        S_ZERO
    } t_state;

    t_state                      r_state;
    logic [mdeg_pkg::THR_W-1:0]  r_threshold;
    logic [mdeg_pkg::RUN_W-1:0]  r_run_length;
    logic [SAMPLE_BITS-1:0]      r_sample;
    logic                        r_last;
    logic [CNT_W-1:0]            r_count;
    logic                        r_confirmed;
    logic [CNT_W-1:0]            r_idx;
    logic                        r_zero;
    logic                        r_tail;
    logic [SAMPLE_BITS-1:0]      r_rdata;
    logic                        r_ovalid;
    logic [SAMPLE_BITS-1:0]      r_gated;
    logic                        r_bl;
    logic                        r_fd;

    logic [SAMPLE_BITS-1:0]      r_store [MAX_RUN_LENGTH];

    logic [CMP_W-1:0]            w_need;
    logic [CMP_W-1:0]            w_cmp_a;
    logic [CMP_W-1:0]            w_cmp_b;
    logic                        w_ge;
    logic                        w_out_free;
    logic                        w_out_load;
    logic                        w_store_we;

    assign pready = 1'b1;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_gated_value = r_gated;
    assign o_burst_last = r_bl;
    assign o_frame_done = r_fd;
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            mdeg_pkg::REG_THRESHOLD: prdata[mdeg_pkg::THR_W-1:0] = r_threshold;
            mdeg_pkg::REG_RUN_LENGTH: prdata[mdeg_pkg::RUN_W-1:0] = r_run_length;
            default: prdata = '0;
        endcase
    end

    always_comb begin
        if (r_run_length == '0) begin
            w_need = CMP_W'(1);
        end else if (CMP_W'(r_run_length) > CMP_W'(MAX_RUN_LENGTH)) begin
            w_need = CMP_W'(MAX_RUN_LENGTH);
        end else begin
            w_need = CMP_W'(r_run_length);
        end
    end

    always_comb begin
        case (r_state)
            S_CLASS: begin
                w_cmp_a = CMP_W'(r_sample);
                w_cmp_b = CMP_W'(r_threshold);
            end
            S_CHECK: begin
                w_cmp_a = CMP_W'(r_count);
                w_cmp_b = w_need;
            end
            S_OUT: begin
                w_cmp_a = CMP_W'(r_idx) + CMP_W'(1);
                w_cmp_b = CMP_W'(r_count);
            end
            default: begin
                w_cmp_a = '0;
                w_cmp_b = '0;
            end
        endcase
        w_ge = (w_cmp_a >= w_cmp_b);
    end

    assign w_store_we = (r_state == S_CLASS) && w_ge && !r_confirmed &&
                        (r_count < CNT_W'(MAX_RUN_LENGTH));

    assign w_out_load = w_out_free &&
                        (((r_state == S_CLASS) && w_ge && r_confirmed) ||
                         (r_state == S_OUT) || (r_state == S_ZERO));

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count[IDX_W-1:0]] <= r_sample;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_store[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_threshold <= mdeg_pkg::THR_RESET;
            r_run_length <= mdeg_pkg::RUN_RESET;
            r_count <= '0;
            r_confirmed <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[2])
                    mdeg_pkg::REG_THRESHOLD: r_threshold <= pwdata[mdeg_pkg::THR_W-1:0];
                    mdeg_pkg::REG_RUN_LENGTH: r_run_length <= pwdata[mdeg_pkg::RUN_W-1:0];
                    default: r_threshold <= r_threshold;
                endcase
            end

            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample_value;
                        r_last <= i_frame_end;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (w_ge) begin
                        if (r_confirmed) begin
                            if (w_out_free) begin
                                r_gated <= r_sample;
                                r_bl <= 1'b1;
                                r_fd <= r_last;
                                if (r_last) begin
                                    r_confirmed <= 1'b0;
                                end
                                r_state <= S_IDLE;
                            end
                        end else begin
                            if (r_count < CNT_W'(MAX_RUN_LENGTH)) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_confirmed <= 1'b0;
                        if (!r_confirmed && (r_count != '0)) begin
                            r_idx <= '0;
                            r_zero <= 1'b1;
                            r_tail <= 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_ZERO;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_ge) begin
                        r_idx <= '0;
                        r_zero <= 1'b0;
                        r_tail <= 1'b0;
                        r_confirmed <= !r_last;
                        r_state <= S_RD;
                    end else if (r_last) begin
                        r_idx <= '0;
                        r_zero <= 1'b1;
                        r_tail <= 1'b0;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_gated <= r_zero ? '0 : r_rdata;
                        r_bl <= w_ge && !r_tail;
                        r_fd <= w_ge && !r_tail && r_last;
                        r_idx <= r_idx + CNT_W'(1);
                        if (w_ge) begin
                            r_count <= '0;
                            r_state <= r_tail ? S_ZERO : S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_ZERO: begin
                    if (w_out_free) begin
                        r_gated <= '0;
                        r_bl <= 1'b1;
                        r_fd <= r_last;
                        r_count <= '0;
                        r_confirmed <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ bench/min_duration_event_gate_unit_tb.sv @@
// Self-checking testbench for the minimum duration event gate: directed and random sample runs.
module min_duration_event_gate_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = mdeg_pkg::SAMPLE_BITS_DEF;
    localparam int MAX_RUN = mdeg_pkg::MAX_RUN_LENGTH_DEF;
    localparam int THR_W = mdeg_pkg::THR_W;
    localparam int RUN_W = mdeg_pkg::RUN_W;
    localparam int ADDR_W = mdeg_pkg::ADDR_W;
    localparam int DATA_W = mdeg_pkg::DATA_W;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SAMPLE = (1 << SW) - 1;

    typedef struct packed {
        logic [SW-1:0] gated;
        logic          burst_last;
        logic          frame_done;
    } t_gate_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [SW-1:0]     i_sample_value = '0;
    logic              i_frame_end = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [SW-1:0]     o_gated_value;
    logic              o_burst_last;
    logic              o_frame_done;

    logic [THR_W-1:0]  thr_cfg = mdeg_pkg::THR_RESET;
    logic [RUN_W-1:0]  run_cfg = mdeg_pkg::RUN_RESET;
    logic [SW-1:0]     held_samples [MAX_RUN];
    int                held_count = 0;
    bit                in_event = 1'b0;

    t_gate_result      expected_results [$];
    bit                stall_en = 1'b1;
    int                error_count = 0;
    int                cycle_count = 0;
    int                items_sent = 0;
    int                results_seen = 0;
    int                bursts_released = 0;
    int                settings_used = 1;

    min_duration_event_gate_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_value (i_sample_value),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gated_value  (o_gated_value),
        .o_burst_last   (o_burst_last),
        .o_frame_done   (o_frame_done)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("min_duration_event_gate_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < 40) begin
            $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                     want);
        end
        error_count++;
    endtask

    function automatic int effective_run_length();
        if (run_cfg == 0) begin
            return 1;
        end else if (run_cfg > MAX_RUN) begin
            return MAX_RUN;
        end
        return int'(run_cfg);
    endfunction

    function automatic void predict_gate_outputs(input logic [SW-1:0] s, input logic fe);
        int need;
        logic [SW-1:0] outs [$];
        t_gate_result r;
        need = effective_run_length();
        if (s >= thr_cfg) begin
            if (in_event) begin
                outs.push_back(s);
            end else begin
                if (held_count < MAX_RUN) begin
                    held_samples[held_count] = s;
                    held_count++;
                end
                if (held_count >= need) begin
                    for (int i = 0; i < held_count; i++) outs.push_back(held_samples[i]);
                    held_count = 0;
                    in_event = 1'b1;
                    bursts_released++;
                end else if (fe) begin
                    for (int i = 0; i < held_count; i++) outs.push_back('0);
                    held_count = 0;
                end
            end
        end else begin
            if (!in_event) begin
                for (int i = 0; i < held_count; i++) outs.push_back('0);
            end
            held_count = 0;
            in_event = 1'b0;
            outs.push_back('0);
        end
        if (fe) begin
            held_count = 0;
            in_event = 1'b0;
        end
        foreach (outs[i]) begin
            r.gated = outs[i];
            r.burst_last = (i == outs.size() - 1);
            r.frame_done = fe && (i == outs.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_gate_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected, gated_value", o_gated_value, -1);
            end else begin
                want = expected_results.pop_front();
                if (o_gated_value !== want.gated) begin
                    report_mismatch("gated_value", o_gated_value, want.gated);
                end
                if (o_burst_last !== want.burst_last) begin
                    report_mismatch("burst_last", o_burst_last, want.burst_last);
                end
                if (o_frame_done !== want.frame_done) begin
                    report_mismatch("frame_done", o_frame_done, want.frame_done);
                end
            end
        end
        i_ready <= !stall_en || ($urandom_range(0, 99) >= 27);
    end

    task automatic send_sample(input logic [SW-1:0] s, input logic fe);
        while (stall_en && $urandom_range(0, 99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_value <= s;
        i_frame_end <= fe;
        do @(posedge i_clk); while (!o_ready);
        predict_gate_outputs(s, fe);
        items_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        mask = (reg_index == mdeg_pkg::REG_THRESHOLD) ? DATA_W'((1 << THR_W) - 1)
                                                      : DATA_W'((1 << RUN_W) - 1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_index == mdeg_pkg::REG_THRESHOLD) begin
            thr_cfg = value[THR_W-1:0];
        end else begin
            run_cfg = value[RUN_W-1:0];
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            report_mismatch("register readback", prdata & mask, value & mask);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [THR_W-1:0] thr, input logic [RUN_W-1:0] len);
        wait_for_results();
        write_register(mdeg_pkg::REG_THRESHOLD, DATA_W'(thr));
        write_register(mdeg_pkg::REG_RUN_LENGTH, DATA_W'(len));
        settings_used++;
    endtask

    function automatic logic [SW-1:0] active_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return SW'(thr_cfg);
        end else if (pick < 14) begin
            return SW'(MAX_SAMPLE);
        end
        return SW'($urandom_range(MAX_SAMPLE, thr_cfg));
    endfunction

    function automatic logic [SW-1:0] inactive_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (thr_cfg == 0) begin
            return '0;
        end else if (pick < 10) begin
            return SW'(thr_cfg - 1);
        end else if (pick < 16) begin
            return '0;
        end
        return SW'($urandom_range(thr_cfg - 1, 0));
    endfunction

    task automatic send_runs(input int item_count);
        int sent;
        int need;
        int target;
        bit end_by_frame;
        logic fe;
        sent = 0;
        while (sent < item_count) begin
            need = effective_run_length();
            if ($urandom_range(0, 99) < 15) begin
                send_sample(SW'($urandom_range(0, MAX_SAMPLE)), $urandom_range(0, 99) < 10);
                sent++;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        target = (need > 1) ? need - 1 : 1;
                    end
                    1: begin
                        target = need;
                    end
                    2: begin
                        target = need + $urandom_range(1, 6);
                    end
                    default: begin
                        target = $urandom_range(1, need);
                    end
                endcase
                end_by_frame = (thr_cfg == 0) || ($urandom_range(0, 99) < 25);
                for (int k = 0; k < target; k++) begin
                    fe = ((k == target - 1) && end_by_frame) || ($urandom_range(0, 99) < 2);
                    send_sample(active_sample(), fe);
                    sent++;
                end
                if (!end_by_frame) begin
                    send_sample(inactive_sample(), $urandom_range(0, 99) < 10);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_default_settings();
        send_sample(16'd32767, 1'b0);
        send_sample(16'd32768, 1'b1);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd0, 1'b0);
    endtask

    task automatic test_short_runs();
        apply_settings(16'd32768, 6'd3);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd40000, 1'b0);
        send_sample(16'd32768, 1'b0);
        send_sample(16'd50000, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd60000, 1'b0);
        send_sample(16'd60000, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd60000, 1'b1);
        send_sample(16'd33000, 1'b0);
        send_sample(16'd34000, 1'b0);
        send_sample(16'd35000, 1'b1);
    endtask

    task automatic test_threshold_extremes();
        apply_settings(16'd0, 6'd0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b1);
        apply_settings(16'd65535, 6'd63);
        send_sample(16'd65534, 1'b0);
        send_sample(16'd65535, 1'b1);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd12345, 1'b0);
    endtask

    task automatic test_random_runs();
        apply_settings(THR_W'($urandom_range(0, MAX_SAMPLE)), RUN_W'($urandom_range(2, 8)));
        send_runs(50);
        apply_settings(16'd0, 6'd63);
        send_runs(60);
        apply_settings(16'd65535, 6'd1);
        send_runs(35);
        stall_en = 1'b0;
        apply_settings(THR_W'($urandom_range(1000, MAX_SAMPLE - 1000)), 6'd32);
        send_runs(60);
        stall_en = 1'b1;
        apply_settings(THR_W'($urandom_range(0, MAX_SAMPLE)), 6'd0);
        send_runs(35);
        apply_settings(THR_W'($urandom_range(0, MAX_SAMPLE)), RUN_W'($urandom_range(1, 12)));
        send_runs(45);
        wait_for_results();
        send_runs(45);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_settings();
        test_short_runs();
        test_threshold_extremes();
        test_random_runs();
        wait_for_results();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d samples under %0d register settings; checked %0d results.",
                 items_sent, settings_used, results_seen);
        $display("Held runs confirmed and released as bursts: %0d.", bursts_released);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("min_duration_event_gate_unit regression: pass");
        end else begin
            $display("min_duration_event_gate_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/mdeg_pkg.sv
src/min_duration_event_gate_unit.sv
bench/min_duration_event_gate_unit_tb.sv
